>>> hw/rtl/ulrb_pkg.sv
// Shared types and constants for the line receive buffer.
// Used by ulrb_front, ulrb_back and uart_line_receive_buffer; no dependencies.
`default_nettype none

package ulrb_pkg;

    // Field widths that the item formats fix.
    localparam int BYTE_W    = 8;
    localparam int MAX_LEN_W = 7;
    localparam int LEN_W     = 6;

    // Depth of the command queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Command codes on the input channel.
    localparam logic CMD_RECEIVE = 1'b0;
    localparam logic CMD_READ    = 1'b1;

    // Line terminator.
    localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'h0A;

    // One input item.
    typedef struct packed {
        logic                 cmd;
        logic                 rx_flag;
        logic [BYTE_W-1:0]    rx_byte;
        logic [MAX_LEN_W-1:0] max_len;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic              status;
        logic [BYTE_W-1:0] data_byte;
        logic              byte_valid;
        logic              last;
        logic [LEN_W-1:0]  line_length;
        logic              overrun;
    } out_item_t;

    // Work kinds that the front part hands to the back part.
    typedef enum logic {
        KIND_STORE = 1'b0,
        KIND_READ  = 1'b1
    } cmd_kind_t;

    // One queued command, already classified.
    typedef struct packed {
        cmd_kind_t         kind;
        logic [BYTE_W-1:0] rx_byte;
        logic [LEN_W-1:0]  limit;
    } q_entry_t;

    // Status of the back part, watched at the top level.
    typedef struct packed {
        logic busy;
        logic overrun;
    } back_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/ulrb_front.sv
// Front part: accepts input items, classifies them and queues the work.
// Depends on ulrb_pkg.
`default_nettype none

module ulrb_front #(
    parameter int MAX_READ = 64
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  ulrb_pkg::in_item_t  s_item,
    output logic                deq_valid,
    input  wire                 deq_ready,
    output ulrb_pkg::q_entry_t  deq_item
);
    import ulrb_pkg::*;

    localparam logic [MAX_LEN_W-1:0] LIMIT_CAP = MAX_LEN_W'(MAX_READ - 1);

    q_entry_t                 q_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [MAX_LEN_W-1:0]     limit_raw;
    logic [MAX_LEN_W-1:0]     limit_sat;
    q_entry_t                 entry;
    logic                     accept;
    logic                     push;
    logic                     pop;

    // Byte limit for a read: max_len minus one, capped at MAX_READ - 1; zero gives the cap.
    always_comb begin
        limit_raw = (s_item.max_len == '0) ? LIMIT_CAP : s_item.max_len - 1'b1;
        limit_sat = (limit_raw > LIMIT_CAP) ? LIMIT_CAP : limit_raw;
    end

    // Classify the item; a receive with the data-ready flag clear has no effect.
    always_comb begin
        entry.kind    = (s_item.cmd == CMD_READ) ? KIND_READ : KIND_STORE;
        entry.rx_byte = s_item.rx_byte;
        entry.limit   = limit_sat[LEN_W-1:0];
    end

    assign s_ready   = (cnt_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign accept    = s_valid && s_ready;
    assign push      = accept && ((s_item.cmd == CMD_READ) || s_item.rx_flag);
    assign deq_valid = (cnt_reg != '0);
    assign deq_item  = q_reg[rd_ptr_reg];
    assign pop       = deq_valid && deq_ready;

    // Queue pointer and fill count updates.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/ulrb_back.sv
// Back part: ring storage, line detection and the line read-out sequencer.
// Depends on ulrb_pkg.
`default_nettype none

module ulrb_back #(
    parameter int RING_DEPTH = 128
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   deq_valid,
    output logic                  deq_ready,
    input  ulrb_pkg::q_entry_t    deq_item,
    output logic                  m_valid,
    input  wire                   m_ready,
    output ulrb_pkg::out_item_t   m_item,
    output ulrb_pkg::back_stat_t  stat
);
    import ulrb_pkg::*;

    localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_START = 3'b010,
        ST_EMIT  = 3'b100
    } state_t;

    logic [BYTE_W-1:0] ring_mem [RING_DEPTH];

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              overrun_reg, overrun_next;
    logic              line_ready_reg, line_ready_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  limit_reg, limit_next;
    logic [BYTE_W-1:0] mem_q_reg;
    out_item_t         out_item_reg, out_item_next;
    logic              out_valid_reg, out_valid_next;

    logic [IDX_W-1:0]  wr_inc;
    logic [IDX_W-1:0]  rd_inc;
    logic [IDX_W-1:0]  rd_addr;
    logic [LEN_W-1:0]  len_inc;
    logic              ring_full;
    logic              ring_empty;
    logic              out_free;
    logic              load_out;
    logic              mem_we;
    logic              stop_now;

    // Ring index arithmetic, wrapping at the ring depth.
    always_comb begin
        wr_inc     = (wr_idx_reg == IDX_LAST) ? '0 : wr_idx_reg + 1'b1;
        rd_inc     = (rd_idx_reg == IDX_LAST) ? '0 : rd_idx_reg + 1'b1;
        ring_full  = (wr_inc == rd_idx_reg);
        ring_empty = (rd_idx_reg == wr_idx_reg);
        len_inc    = len_reg + 1'b1;
        out_free   = !out_valid_reg || m_ready;
        // The popped byte ends the read on a newline, the limit or an empty ring.
        stop_now   = (mem_q_reg == NEWLINE_CODE) || (len_inc == limit_reg)
                     || (rd_inc == wr_idx_reg);
    end

    // Command sequencer.
    always_comb begin
        state_next      = state_reg;
        wr_idx_next     = wr_idx_reg;
        rd_idx_next     = rd_idx_reg;
        overrun_next    = overrun_reg;
        line_ready_next = line_ready_reg;
        len_next        = len_reg;
        limit_next      = limit_reg;
        out_item_next   = out_item_reg;
        load_out        = 1'b0;
        mem_we          = 1'b0;
        deq_ready       = 1'b0;
        rd_addr         = rd_idx_reg;

        case (state_reg)
            ST_IDLE: begin
                deq_ready = 1'b1;
                if (deq_valid) begin
                    if (deq_item.kind == KIND_READ) begin
                        limit_next = deq_item.limit;
                        state_next = ST_START;
                    end else if (ring_full) begin
                        overrun_next = 1'b1;
                    end else begin
                        mem_we      = 1'b1;
                        wr_idx_next = wr_inc;
                        if (deq_item.rx_byte == NEWLINE_CODE) begin
                            line_ready_next = 1'b1;
                        end
                    end
                end
            end
            ST_START: begin
                if (!line_ready_reg) begin
                    // No line waiting: a single empty result.
                    if (out_free) begin
                        load_out                  = 1'b1;
                        out_item_next             = '0;
                        out_item_next.last        = 1'b1;
                        out_item_next.overrun     = overrun_reg;
                        state_next                = ST_IDLE;
                    end
                end else if (ring_empty || (limit_reg == '0)) begin
                    // A read that delivers no byte still consumes the line.
                    if (out_free) begin
                        load_out                  = 1'b1;
                        out_item_next             = '0;
                        out_item_next.status      = 1'b1;
                        out_item_next.last        = 1'b1;
                        out_item_next.overrun     = overrun_reg;
                        line_ready_next           = 1'b0;
                        state_next                = ST_IDLE;
                    end
                end else begin
                    len_next   = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // The head byte is in mem_q_reg; fetch the next one as it is popped.
                if (out_free) begin
                    load_out                  = 1'b1;
                    rd_addr                   = rd_inc;
                    rd_idx_next               = rd_inc;
                    len_next                  = len_inc;
                    out_item_next.status      = 1'b1;
                    out_item_next.data_byte   = mem_q_reg;
                    out_item_next.byte_valid  = 1'b1;
                    out_item_next.last        = stop_now;
                    out_item_next.line_length = len_inc;
                    out_item_next.overrun     = overrun_reg;
                    if (stop_now) begin
                        line_ready_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = load_out ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            wr_idx_reg     <= '0;
            rd_idx_reg     <= '0;
            overrun_reg    <= 1'b0;
            line_ready_reg <= 1'b0;
            len_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            wr_idx_reg     <= wr_idx_next;
            rd_idx_reg     <= rd_idx_next;
            overrun_reg    <= overrun_next;
            line_ready_reg <= line_ready_next;
            len_reg        <= len_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        limit_reg    <= limit_next;
        out_item_reg <= out_item_next;
    end

    // Ring memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ring_mem[wr_idx_reg] <= deq_item.rx_byte;
        end
        mem_q_reg <= ring_mem[rd_addr];
    end

    assign m_valid      = out_valid_reg;
    assign m_item       = out_item_reg;
    assign stat.busy    = (state_reg != ST_IDLE);
    assign stat.overrun = overrun_reg;

endmodule

`default_nettype wire

>>> hw/rtl/uart_line_receive_buffer.sv
// Top level of the serial line receive buffer: front queue plus back sequencer.
// Depends on ulrb_pkg, ulrb_front and ulrb_back.
//
// A receive item stores its byte in a ring of RING_DEPTH slots (one slot is
// always left empty); a full ring drops the byte and sets the sticky overrun
// flag, and a stored newline marks a line as ready. A read item delivers its
// bytes one byte per cycle while the output accepts them, set by the single
// read port of the ring memory; a read with no line ready, or one that
// delivers nothing, gives a single result. Two queued items decouple the
// input from the sequencer, and a result register decouples the sequencer
// from the output. Every result carries the current overrun flag, and the
// last result of a read carries the length.
`default_nettype none

module uart_line_receive_buffer #(
    parameter int RING_DEPTH = 128,
    parameter int MAX_READ   = 64
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  ulrb_pkg::in_item_t   s_item,
    output logic                 m_valid,
    input  wire                  m_ready,
    output ulrb_pkg::out_item_t  m_item
);
    import ulrb_pkg::*;

    logic       deq_valid;
    logic       deq_ready;
    q_entry_t   deq_item;
    back_stat_t stat;

    ulrb_front #(
        .MAX_READ (MAX_READ)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .deq_valid (deq_valid),
        .deq_ready (deq_ready),
        .deq_item  (deq_item)
    );

    ulrb_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .deq_valid (deq_valid),
        .deq_ready (deq_ready),
        .deq_item  (deq_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .stat      (stat)
    );

    // The sequencer takes no new command while a read is in progress.
    assert property (@(posedge aclk) disable iff (!aresetn)
        deq_ready |-> !stat.busy)
        else $error("command taken while a read is in progress");

    // The overrun flag is sticky until reset.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !$fell(stat.overrun))
        else $error("overrun flag cleared without reset");

    // A result without a byte is always the sole, final result with zero length.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_item.byte_valid) |-> (m_item.last && (m_item.line_length == '0)))
        else $error("byte-less result is not a final zero-length result");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking bench for uart_line_receive_buffer: random and directed items, a
// ring and line predictor, and a result checker. Depends on it and on ulrb_pkg.
`default_nettype none

module tb_top;
    import ulrb_pkg::*;

    localparam int RING_SLOTS       = 128;
    localparam int LINE_CAP         = 64;
    localparam int RANDOM_PER_PHASE = 10;
    localparam int HOLDOFF_CYCLES   = 200;
    localparam int TAIL_CYCLES      = 20;
    localparam int RUN_LIMIT        = 4_000_000;

    // Copies of the buffer state: one follows the accepted items, one plans stimulus.
    localparam int LIVE = 0;
    localparam int PLAN = 1;

    // Idle patterns of the run, in order.
    localparam logic [1:0] PH_CALM     = 2'd0;
    localparam logic [1:0] PH_TX_IDLE  = 2'd1;
    localparam logic [1:0] PH_RX_STALL = 2'd2;
    localparam logic [1:0] PH_BOTH     = 2'd3;
    localparam int TX_IDLE_PCT [4] = '{0, 47, 0, 21};
    localparam int RX_STALL_PCT [4] = '{0, 0, 47, 21};

    typedef struct packed {
        in_item_t   item;
        logic [1:0] phase;
        logic       drain;
        logic       hold;
    } stim_entry_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    // Ring state, one copy per use.
    logic [7:0] ring_mem [2][RING_SLOTS];
    int         wr_ptr [2];
    int         rd_ptr [2];
    bit         overrun_seen [2];
    bit         line_rdy [2];

    stim_entry_t items_todo [$];
    out_item_t   results_due [$];
    out_item_t   ring_step_out [$];
    out_item_t   want_item;

    logic [1:0] gen_phase = PH_CALM;
    logic       gen_drain = 1'b0;
    logic       gen_hold  = 1'b0;
    logic [1:0] cur_phase = PH_CALM;
    logic       in_taken  = 1'b0;
    int         holdoff_requests = 0;
    int         holdoff_served   = 0;
    int         hold_left        = 0;
    int         items_in         = 0;
    int         results_checked  = 0;
    int         bad_results      = 0;

    uart_line_receive_buffer #(
        .RING_DEPTH (RING_SLOTS),
        .MAX_READ   (LINE_CAP)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #5 aclk = ~aclk;

    // Apply one item to a copy of the ring state and list the results it causes.
    function automatic int ring_step(int sel, in_item_t it);
        int         limit;
        int         n;
        logic [7:0] c;
        out_item_t  r;
        ring_step_out.delete();
        if (it.cmd == CMD_RECEIVE) begin
            // A flagged byte is stored unless only the reserved slot is left.
            if (it.rx_flag) begin
                if ((wr_ptr[sel] + 1) % RING_SLOTS == rd_ptr[sel]) begin
                    overrun_seen[sel] = 1'b1;
                end else begin
                    ring_mem[sel][wr_ptr[sel]] = it.rx_byte;
                    wr_ptr[sel] = (wr_ptr[sel] + 1) % RING_SLOTS;
                    if (it.rx_byte == NEWLINE_CODE) begin
                        line_rdy[sel] = 1'b1;
                    end
                end
            end
            return 0;
        end
        r = '0;
        r.overrun = overrun_seen[sel];
        r.last = 1'b1;
        if (!line_rdy[sel]) begin
            ring_step_out.push_back(r);
            return 1;
        end
        // Pop up to the byte limit, stopping after a newline or on an empty ring.
        limit = (it.max_len == '0) ? LINE_CAP - 1 : int'(it.max_len) - 1;
        if (limit > LINE_CAP - 1) begin
            limit = LINE_CAP - 1;
        end
        n = 0;
        r.status = 1'b1;
        while (rd_ptr[sel] != wr_ptr[sel] && n < limit) begin
            c = ring_mem[sel][rd_ptr[sel]];
            rd_ptr[sel] = (rd_ptr[sel] + 1) % RING_SLOTS;
            n++;
            r.data_byte   = c;
            r.byte_valid  = 1'b1;
            r.line_length = 6'(n);
            r.last = (c == NEWLINE_CODE) || (rd_ptr[sel] == wr_ptr[sel]) || (n == limit);
            ring_step_out.push_back(r);
            if (c == NEWLINE_CODE) begin
                break;
            end
        end
        line_rdy[sel] = 1'b0;
        // A read that delivers nothing still reports one final result.
        if (n == 0) begin
            ring_step_out.push_back(r);
        end
        return ring_step_out.size();
    endfunction

    // Append one item to the stimulus and track it in the planning copy.
    function automatic int queue_item(logic cmd, logic flag, logic [7:0] b, logic [6:0] ml);
        stim_entry_t e;
        e.item.cmd     = cmd;
        e.item.rx_flag = flag;
        e.item.rx_byte = b;
        e.item.max_len = ml;
        e.phase = gen_phase;
        e.drain = gen_drain;
        e.hold  = gen_hold;
        gen_drain = 1'b0;
        gen_hold  = 1'b0;
        items_todo.push_back(e);
        return ring_step(PLAN, e.item);
    endfunction

    function automatic void rx_item(logic flag, logic [7:0] b);
        void'(queue_item(CMD_RECEIVE, flag, b, 7'($urandom_range(1, LINE_CAP))));
    endfunction

    function automatic int read_item(logic [6:0] ml);
        return queue_item(CMD_READ, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), ml);
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        return (b == NEWLINE_CODE) ? 8'h0B : b;
    endfunction

    // Input side: offer the next item once the previous one is taken, unless idling or draining.
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || in_taken)) begin
            if (items_todo.size() == 0
                    || (items_todo[0].drain && results_due.size() != 0)
                    || ($urandom_range(0, 99) < TX_IDLE_PCT[cur_phase])) begin
                s_valid <= 1'b0;
            end else begin
                s_item    <= items_todo[0].item;
                s_valid   <= 1'b1;
                cur_phase <= items_todo[0].phase;
                if (items_todo[0].hold) begin
                    holdoff_requests <= holdoff_requests + 1;
                end
                void'(items_todo.pop_front());
            end
        end
    end

    // Output side: random stalls, plus long hold-offs counted here in cycles.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holdoff_served != holdoff_requests) begin
            holdoff_served <= holdoff_requests;
            hold_left      <= HOLDOFF_CYCLES;
            m_ready        <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= RX_STALL_PCT[cur_phase]);
        end
    end

    // Predict on every accepted item and check every accepted result.
    always @(posedge aclk) begin
        in_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            items_in++;
            void'(ring_step(LIVE, s_item));
            foreach (ring_step_out[k]) begin
                results_due.push_back(ring_step_out[k]);
            end
        end
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (results_due.size() == 0) begin
                bad_results++;
                if (bad_results <= 10) begin
                    $display("%0t: result with nothing expected: %p", $time, m_item);
                end
            end else begin
                want_item = results_due.pop_front();
                if (m_item !== want_item) begin
                    bad_results++;
                    if (bad_results <= 10) begin
                        $display("%0t: want status %0d byte %02h valid %0d last %0d len %0d ovr %0d",
                                 $time, want_item.status, want_item.data_byte,
                                 want_item.byte_valid, want_item.last,
                                 want_item.line_length, want_item.overrun);
                        $display("%0t:  got status %0d byte %02h valid %0d last %0d len %0d ovr %0d",
                                 $time, m_item.status, m_item.data_byte, m_item.byte_valid,
                                 m_item.last, m_item.line_length, m_item.overrun);
                    end
                end
            end
        end
    end

    // Build the stimulus, run reset, then wait for every result.
    initial begin
        int target;
        int occ;
        int kind;
        int len;

        // Directed: reads with no line ready, an ignored byte, limits and a cleared line.
        void'(read_item(7'd64));
        rx_item(1'b0, NEWLINE_CODE);
        void'(read_item(7'd1));
        rx_item(1'b1, 8'h00);
        rx_item(1'b1, 8'hFF);
        rx_item(1'b1, NEWLINE_CODE);
        void'(read_item(7'd64));
        rx_item(1'b1, 8'h41);
        rx_item(1'b1, NEWLINE_CODE);
        void'(read_item(7'd1));
        void'(read_item(7'd64));
        rx_item(1'b1, 8'h55);
        rx_item(1'b1, 8'hAA);
        rx_item(1'b1, NEWLINE_CODE);
        void'(read_item(7'd2));

        for (int ph = 0; ph < 4; ph++) begin
            gen_phase = 2'(ph);
            gen_drain = (gen_phase != PH_CALM);
            if (gen_phase == PH_RX_STALL) begin
                // Lines and reads while the output is held off, so the input backs up.
                gen_hold = 1'b1;
                repeat (3) begin
                    rx_item(1'b1, plain_byte());
                    rx_item(1'b1, plain_byte());
                    rx_item(1'b1, NEWLINE_CODE);
                    void'(read_item(7'd64));
                end
            end
            target = items_todo.size() + RANDOM_PER_PHASE;
            while (items_todo.size() < target) begin
                occ  = (wr_ptr[PLAN] - rd_ptr[PLAN] + RING_SLOTS) % RING_SLOTS;
                kind = $urandom_range(0, 99);
                if (occ > 90) begin
                    // Keep the ring from filling with no line ready.
                    if (line_rdy[PLAN]) begin
                        void'(read_item(7'd64));
                    end else begin
                        rx_item(1'b1, NEWLINE_CODE);
                    end
                end else if (kind < 35) begin
                    len = $urandom_range(0, 12);
                    repeat (len) rx_item(1'b1, plain_byte());
                    rx_item(1'b1, NEWLINE_CODE);
                end else if (kind < 75) begin
                    if ($urandom_range(0, 3) == 0) begin
                        void'(read_item(7'($urandom_range(1, 4))));
                    end else begin
                        void'(read_item(7'($urandom_range(5, LINE_CAP))));
                    end
                end else if (kind < 88) begin
                    repeat ($urandom_range(1, 5)) rx_item(1'b1, 8'($urandom_range(0, 255)));
                end else begin
                    rx_item(1'b0, 8'($urandom_range(0, 255)));
                end
            end
        end

        // Fill the ring with plain bytes and drop two more so that overrun is raised.
        gen_drain = 1'b1;
        while ((wr_ptr[PLAN] + 1) % RING_SLOTS != rd_ptr[PLAN]) begin
            rx_item(1'b1, plain_byte());
        end
        rx_item(1'b1, plain_byte());
        rx_item(1'b1, plain_byte());
        // Clear line-ready, and show that a dropped newline sets nothing.
        void'(read_item(7'd1));
        rx_item(1'b1, NEWLINE_CODE);
        void'(read_item(7'd64));

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (items_todo.size() != 0 || s_valid) @(posedge aclk);
        while (results_due.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Run covered %0d input items and %0d results, %0d of them wrong.",
                 items_in, results_checked, bad_results);
        $display("It went through capped and empty reads, ring overrun and four idle patterns.");
        if (bad_results == 0 && results_due.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Guard against a hung run.
    initial begin
        #(RUN_LIMIT);
        $display("Run stopped by the time limit with %0d results pending.", results_due.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
hw/rtl/ulrb_pkg.sv
hw/rtl/ulrb_front.sv
hw/rtl/ulrb_back.sv
hw/rtl/uart_line_receive_buffer.sv
tb/tb_top.sv
